/* rtl/mds_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mds_pkg
// Shared types, sizes and helpers for the multibyte delimiter splitter.
// ----------------------------------------------------------------------------
package mds_pkg;

  localparam int MAX_DELIM  = 8;
  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 32;
  localparam int LEN_W      = 4;
  localparam int DSEL_W     = $clog2(MAX_DELIM);
  localparam int CFG_DATA_W = BYTE_W * MAX_DELIM;
  localparam int CFG_IDX_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELIM_BYTES  = 1'b0,
    REG_DELIM_LENGTH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_stream;
  } in_beat_t;

  typedef struct packed {
    logic [CNT_W-1:0] seg_offset;
    logic [CNT_W-1:0] seg_size;
    logic             final_segment;
  } out_beat_t;

  typedef struct packed {
    logic shift;
    logic in_window;
  } cell_ctl_t;

  // saturating add of a small amount to a counter
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [LEN_W:0]   b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + (CNT_W+1)'(b);
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/mds_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mds_cell
// One window slot: holds a byte, passes it on, and compares the byte that
// enters it against its delimiter byte.
// ----------------------------------------------------------------------------
module mds_cell
  import mds_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_ctl_t         ctl,
  input  wire logic [BYTE_W-1:0] byte_in,
  input  wire logic [BYTE_W-1:0] delim_byte,
  input  wire logic              hit_in,
  output logic      [BYTE_W-1:0] byte_out,
  output logic                   hit_out
);

  logic [BYTE_W-1:0] byte_q;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      byte_q <= byte_in;
    end
  end

  assign byte_out = byte_q;
  // slots past the delimiter length always agree
  assign hit_out  = hit_in & (!ctl.in_window | (byte_in == delim_byte));

endmodule
`default_nettype wire

/* rtl/multibyte_delimiter_splitter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multibyte_delimiter_splitter
// Cuts a byte stream at a 1 to 8 byte delimiter and reports each segment as
// an offset and a size.
// ----------------------------------------------------------------------------
// output: a segment beat is registered and valid in the cycle after the byte that closes it
// throughput: one byte per cycle unless a waiting segment beat is held; the
//   compare runs across the cell row in the same cycle the byte enters slot 0
// reset: clears the window, counters and output valid flag; delimiter
//   becomes one zero byte
module multibyte_delimiter_splitter
  import mds_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_beat_t              in_beat,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_beat_t                  out_beat,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CFG_DATA_W-1:0] delim_bytes;
  logic [LEN_W-1:0]      delim_length;
  logic [LEN_W-1:0]      len_eff;

  logic [LEN_W-1:0]      fill;
  logic [CNT_W-1:0]      stream_position;
  logic [CNT_W-1:0]      current_offset;
  logic [CNT_W-1:0]      current_size;

  logic                  accept;
  logic [LEN_W:0]        fill_p1;
  logic                  over;
  logic [LEN_W:0]        shift_cnt;
  logic [LEN_W-1:0]      fill_next;
  logic                  match;
  logic [CNT_W-1:0]      size_shifted;
  logic [CNT_W-1:0]      tail_size;
  logic [CNT_W-1:0]      pos_p1;

  logic [BYTE_W-1:0]     delim_arr [MAX_DELIM];
  logic [BYTE_W-1:0]     cell_byte [MAX_DELIM];
  logic [MAX_DELIM:0]    hit_chain;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      delim_bytes  <= '0;
      delim_length <= LEN_W'(1);
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_DELIM_BYTES:  delim_bytes  <= cfg_data;
        REG_DELIM_LENGTH: delim_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len_eff = delim_length;
    if (len_eff == '0) begin
      len_eff = LEN_W'(1);
    end
    if (len_eff > LEN_W'(MAX_DELIM)) begin
      len_eff = LEN_W'(MAX_DELIM);
    end
  end

  // cell row: slot 0 takes the new byte, slot i holds the byte i beats old
  assign hit_chain[0] = 1'b1;

  for (genvar i = 0; i < MAX_DELIM; i++) begin : g_cell
    logic [LEN_W-1:0]  didx;
    logic [BYTE_W-1:0] byte_in;
    cell_ctl_t         ctl;

    assign delim_arr[i]  = delim_bytes[i*BYTE_W +: BYTE_W];
    // oldest window byte lines up with the first delimiter byte
    assign didx          = len_eff - LEN_W'(i) - LEN_W'(1);
    assign ctl.shift     = accept;
    assign ctl.in_window = LEN_W'(i) < len_eff;

    if (i == 0) begin : g_head
      assign byte_in = in_beat.data_byte;
    end else begin : g_body
      assign byte_in = cell_byte[i-1];
    end

    mds_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .byte_in    (byte_in),
      .delim_byte (delim_arr[didx[DSEL_W-1:0]]),
      .hit_in     (hit_chain[i]),
      .byte_out   (cell_byte[i]),
      .hit_out    (hit_chain[i+1])
    );
  end

  // window bookkeeping: bytes beyond the length leave and join the segment
  assign accept       = in_valid & in_ready;
  assign in_ready     = !out_valid | out_ready;
  assign fill_p1      = {1'b0, fill} + (LEN_W+1)'(1);
  assign over         = fill_p1 > {1'b0, len_eff};
  assign shift_cnt    = over ? (fill_p1 - {1'b0, len_eff}) : '0;
  assign fill_next    = over ? len_eff : fill_p1[LEN_W-1:0];
  assign match        = (fill_next == len_eff) & hit_chain[MAX_DELIM];
  assign size_shifted = sat_add(current_size, shift_cnt);
  assign tail_size    = sat_add(current_size, fill_p1);
  assign pos_p1       = sat_add(stream_position, (LEN_W+1)'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      fill            <= '0;
      stream_position <= '0;
      current_offset  <= '0;
      current_size    <= '0;
    end else if (accept) begin
      if (in_beat.end_of_stream) begin
        fill            <= '0;
        stream_position <= '0;
        current_offset  <= '0;
        current_size    <= '0;
      end else if (match) begin
        fill            <= '0;
        stream_position <= pos_p1;
        current_offset  <= pos_p1;
        current_size    <= '0;
      end else begin
        fill            <= fill_next;
        stream_position <= pos_p1;
        current_size    <= size_shifted;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept & (match | in_beat.end_of_stream)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept & (match | in_beat.end_of_stream)) begin
      out_beat.seg_offset    <= current_offset;
      out_beat.seg_size      <= match ? size_shifted : tail_size;
      out_beat.final_segment <= in_beat.end_of_stream;
    end
  end

endmodule
`default_nettype wire

/* dv/mds_segment_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mds_segment_checker
// Watches the byte, segment and register ports of the delimiter splitter,
// predicts every segment beat from the accepted bytes and the current
// delimiter, and compares each accepted segment beat field by field.
// ----------------------------------------------------------------------------
module mds_segment_checker
  import mds_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_beat_t              in_beat,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_beat_t             out_beat,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  logic [CFG_DATA_W-1:0] delim_word;
  logic [LEN_W-1:0]      delim_len;
  logic [BYTE_W-1:0]     win [MAX_DELIM];
  logic [LEN_W-1:0]      win_fill;
  logic [CNT_W-1:0]      stream_pos;
  logic [CNT_W-1:0]      seg_start;
  logic [CNT_W-1:0]      seg_len;
  out_beat_t             expected_segs [$];

  function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] a, int unsigned n);
    logic [CNT_W:0] s;
    s = {1'b0, a} + n;
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  // length in use: zero acts as one, anything above the window acts as full
  function automatic int active_len();
    if (delim_len == 0) return 1;
    if (delim_len > MAX_DELIM) return MAX_DELIM;
    return int'(delim_len);
  endfunction

  task automatic clear_stream();
    win_fill   = '0;
    stream_pos = '0;
    seg_start  = '0;
    seg_len    = '0;
  endtask

  // oldest window byte leaves and joins the open segment
  task automatic drop_oldest();
    if (win_fill == 0) return;
    for (int k = 1; k < MAX_DELIM; k++)
      if (k < win_fill) win[k-1] = win[k];
    win_fill--;
    seg_len = bump(seg_len, 1);
  endtask

  task automatic split_byte(input in_beat_t b, output bit has_seg, output out_beat_t seg);
    int len;
    bit hit;
    len     = active_len();
    has_seg = 1'b0;
    seg     = '0;
    if (win_fill >= MAX_DELIM) drop_oldest();
    if (win_fill < MAX_DELIM) begin
      win[win_fill] = b.data_byte;
      win_fill++;
    end
    while (win_fill > len) drop_oldest();

    hit = (win_fill == len);
    for (int k = 0; k < MAX_DELIM; k++)
      if (k < len && win[k] != delim_word[BYTE_W*k +: BYTE_W]) hit = 1'b0;

    if (hit) begin
      has_seg           = 1'b1;
      seg.seg_offset    = seg_start;
      seg.seg_size      = seg_len;
      seg.final_segment = b.end_of_stream;
      win_fill          = '0;
      seg_start         = bump(stream_pos, 1);
      seg_len           = '0;
      stream_pos        = bump(stream_pos, 1);
      if (b.end_of_stream) clear_stream();
    end else begin
      stream_pos = bump(stream_pos, 1);
      if (b.end_of_stream) begin
        // trailing bytes still in the window belong to the final segment
        has_seg           = 1'b1;
        seg.seg_offset    = seg_start;
        seg.seg_size      = bump(seg_len, win_fill);
        seg.final_segment = 1'b1;
        clear_stream();
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    bit        has_seg;
    out_beat_t seg;
    out_beat_t want;
    if (rst) begin
      delim_word = '0;
      delim_len  = LEN_W'(1);
      for (int k = 0; k < MAX_DELIM; k++) win[k] = '0;
      clear_stream();
      expected_segs.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_DELIM_BYTES:  delim_word = cfg_data;
          REG_DELIM_LENGTH: delim_len  = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        if (expected_segs.size() == 0) begin
          fail_count++;
          $error("segment beat with none expected: offset %0d size %0d final %0b",
                 out_beat.seg_offset, out_beat.seg_size, out_beat.final_segment);
        end else begin
          want = expected_segs.pop_front();
          if (out_beat.seg_offset !== want.seg_offset) begin
            fail_count++;
            $error("seg_offset: expected %0d, got %0d", want.seg_offset,
                   out_beat.seg_offset);
          end
          if (out_beat.seg_size !== want.seg_size) begin
            fail_count++;
            $error("seg_size: expected %0d, got %0d", want.seg_size, out_beat.seg_size);
          end
          if (out_beat.final_segment !== want.final_segment) begin
            fail_count++;
            $error("final_segment: expected %0b, got %0b", want.final_segment,
                   out_beat.final_segment);
          end
        end
      end

      if (in_valid && in_ready) begin
        split_byte(in_beat, has_seg, seg);
        if (has_seg) expected_segs.push_back(seg);
      end
    end
    pending <= expected_segs.size();
  end

endmodule

/* dv/multibyte_delimiter_splitter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multibyte_delimiter_splitter_tb
// Drives byte streams and delimiter settings into the splitter with bursty
// input and a stalling receiver; the segment checker beside the block
// predicts and compares, and this top reports the verdict.
// ----------------------------------------------------------------------------
module multibyte_delimiter_splitter_tb;
  import mds_pkg::*;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_beat_t              in_beat   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_beat_t             out_beat;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int          fail_count;
  int          pending;
  int          holds_requested = 0;
  int unsigned beats_sent      = 0;
  int unsigned burst_left      = 0;
  int unsigned gap_cycles      = 0;
  logic        steady          = 1'b0;

  always #5 clk = ~clk;

  multibyte_delimiter_splitter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mds_segment_checker seg_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_beat    (in_beat),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_beat   (out_beat),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // offer one byte beat, return at the edge that takes it
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eos);
    if (gap_cycles > 0) begin
      in_valid <= 1'b0;
      repeat (gap_cycles) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= '{data_byte: b, end_of_stream: eos};
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    if (steady || burst_left > 0) begin
      gap_cycles = 0;
      if (burst_left > 0) burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap_cycles = $urandom_range(1, 8);
    end
  endtask

  // stop offering and wait for every outstanding segment beat
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_delimiter(input logic [CFG_DATA_W-1:0] word, input logic [LEN_W-1:0] len);
    cfg_write <= 1'b1;
    cfg_index <= REG_DELIM_BYTES;
    cfg_data  <= word;
    @(posedge clk);
    cfg_index <= REG_DELIM_LENGTH;
    cfg_data  <= CFG_DATA_W'(len);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // mostly delimiter bytes so partial matches show up often
  function automatic logic [BYTE_W-1:0] noise_byte(logic [CFG_DATA_W-1:0] word, int eff);
    if ($urandom_range(0, 9) < 6) return word[BYTE_W*$urandom_range(0, eff-1) +: BYTE_W];
    return BYTE_W'($urandom);
  endfunction

  initial begin : receiver
    int          holds_done;
    int          mode;
    int unsigned tick;
    holds_done = 0;
    mode       = 0;
    tick       = 0;
    forever begin
      if (holds_requested > holds_done) begin
        // long hold-off so the block backs up into its input
        holds_done++;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      if (tick % 64 == 0) mode = $urandom_range(0, 3);
      tick++;
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= tick[2];
      endcase
      @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] word;
    logic [LEN_W-1:0]      len;
    logic [BYTE_W-1:0]     sym_a, sym_b;
    logic                  eos;
    int                    eff, kind, n, phase;
    int unsigned           budget, stop_at;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset delimiter is one zero byte: empty segments, end on a match
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h5A, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h37, 1'b1);
    drain();

    // length above the window acts as eight; stream shorter than delimiter
    word = 64'hFE01_5AA5_C33C_00FF;
    load_delimiter(word, 4'd15);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    for (int k = 0; k < MAX_DELIM; k++)
      send_byte(word[BYTE_W*k +: BYTE_W], k == MAX_DELIM - 1);
    drain();

    // length zero acts as one
    load_delimiter(word, 4'd0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    drain();

    // shrink the length while a stream is open
    load_delimiter(64'h0605, 4'd4);
    for (int k = 1; k <= 5; k++) send_byte(BYTE_W'(k), 1'b0);
    drain();
    load_delimiter(64'h0605, 4'd2);
    send_byte(8'h06, 1'b0);
    send_byte(8'h07, 1'b1);
    drain();

    stop_at = beats_sent + 1100;
    phase   = 0;
    while (beats_sent < stop_at) begin
      phase++;
      case ($urandom_range(0, 9))
        0:       len = 4'd0;
        1:       len = LEN_W'($urandom_range(9, 15));
        2:       len = 4'd1;
        3:       len = 4'd8;
        default: len = LEN_W'($urandom_range(1, 8));
      endcase
      if ($urandom_range(0, 1)) begin
        word = {$urandom, $urandom};
      end else begin
        // two-symbol delimiters give self-overlapping patterns
        sym_a = BYTE_W'($urandom);
        sym_b = BYTE_W'($urandom);
        for (int k = 0; k < MAX_DELIM; k++)
          word[BYTE_W*k +: BYTE_W] = $urandom_range(0, 1) ? sym_a : sym_b;
      end
      steady = ($urandom_range(0, 3) == 0);
      if (phase == 3) begin
        len    = 4'd1;
        steady = 1'b1;
        holds_requested++;
      end
      eff = (len == 0) ? 1 : (len > MAX_DELIM) ? MAX_DELIM : int'(len);
      load_delimiter(word, len);

      budget = beats_sent + $urandom_range(30, 120);
      while (beats_sent < budget) begin
        kind = (phase == 3) ? 0 : $urandom_range(0, 9);
        if (kind <= 3) begin
          eos = ($urandom_range(0, 9) == 0);
          for (int k = 0; k < eff; k++)
            send_byte(word[BYTE_W*k +: BYTE_W], (k == eff - 1) && eos);
        end else if (kind <= 6) begin
          n = $urandom_range(1, 6);
          repeat (n) send_byte(noise_byte(word, eff), 1'b0);
        end else if (kind <= 8) begin
          // delimiter prefix broken by a random byte
          n = $urandom_range(0, eff - 1);
          for (int k = 0; k < n; k++) send_byte(word[BYTE_W*k +: BYTE_W], 1'b0);
          send_byte(BYTE_W'($urandom), 1'b0);
        end else begin
          send_byte(noise_byte(word, eff), 1'b1);
        end
      end
      // some phases leave the stream open across the next register write
      if ($urandom_range(0, 9) < 7) send_byte(noise_byte(word, eff), 1'b1);
      steady = 1'b0;
      drain();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
